[hw/rtl/circle_raster_by_equation_macros.svh]
// ---------------------------------------------------------------------------
// Circle raster assertion macros
// Concurrent check helpers, sampled on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef CIRCLE_RASTER_BY_EQUATION_MACROS_SVH
`define CIRCLE_RASTER_BY_EQUATION_MACROS_SVH

// Same-cycle implication.
`define CRBE_ASSERT_THEN(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CRBE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/crbe_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Circle raster package
// Register indexes, state encodings and status bundles shared by the block.
// ---------------------------------------------------------------------------
package crbe_pkg;

  localparam int CFG_IDX_BITS = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_RADIUS   = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIFF,
    ST_ROOT,
    ST_EMIT
  } crbe_state_t;

  typedef enum logic [1:0] {
    EM_IDLE,
    EM_UPPER,
    EM_LOWER
  } emit_state_t;

  typedef struct packed {
    logic done;
    logic exact;
  } sqrt_stat_t;

  typedef struct packed {
    logic busy;
    logic done;
  } emit_stat_t;

endpackage

[hw/rtl/crbe_in_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Circle raster input channel
// Valid/ready channel carrying the restart flag of one step transaction.
// ---------------------------------------------------------------------------
interface crbe_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

[hw/rtl/crbe_out_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Circle raster result channel
// Valid/ready channel carrying one plotted pixel per transaction.
// ---------------------------------------------------------------------------
interface crbe_out_if #(
  parameter int PIX_BITS = 12
);
  logic                       valid;
  logic                       ready;
  logic signed [PIX_BITS-1:0] pixel_x;
  logic signed [PIX_BITS-1:0] pixel_y;
  logic                       lower_half;
  logic                       last_pixel;

  modport source (output valid, output pixel_x, output pixel_y, output lower_half,
                  output last_pixel, input ready);
  modport sink (input valid, input pixel_x, input pixel_y, input lower_half,
                input last_pixel, output ready);
endinterface

[hw/rtl/crbe_cfg_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Circle raster configuration channel
// Valid/ready write channel carrying a register index and write data.
// ---------------------------------------------------------------------------
interface crbe_cfg_if #(
  parameter int DATA_BITS = 10
);
  logic                               valid;
  logic                               ready;
  logic [crbe_pkg::CFG_IDX_BITS-1:0]  index;
  logic [DATA_BITS-1:0]               data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[hw/rtl/crbe_isqrt.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Circle raster square root unit
// Bit-serial restoring integer square root: two radicand bits shift in and
// one root bit resolves per cycle; exact flags a zero final remainder.
// ---------------------------------------------------------------------------
module crbe_isqrt #(
  parameter int COORD_BITS = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [2*COORD_BITS-1:0]    radicand,
  output logic [COORD_BITS-1:0]      root,
  output crbe_pkg::sqrt_stat_t       stat
);
  import crbe_pkg::*;

  localparam int RAD_BITS = 2 * COORD_BITS;
  localparam int REM_BITS = COORD_BITS + 1;
  localparam int SH_BITS  = COORD_BITS + 3;
  localparam int CNT_BITS = $clog2(COORD_BITS);

  logic [RAD_BITS-1:0]   rad_r;
  logic [REM_BITS-1:0]   rem_r;
  logic [COORD_BITS-1:0] root_r;
  logic [CNT_BITS-1:0]   cnt_r;
  logic                  busy_r;
  logic                  done_r;

  logic [SH_BITS-1:0]    rem_sh;
  logic [SH_BITS-1:0]    trial;
  logic [SH_BITS-1:0]    rem_sub;
  logic                  take;

  assign rem_sh  = {rem_r, rad_r[RAD_BITS-1 -: 2]};
  assign trial   = {1'b0, root_r, 2'b01};
  assign take    = (rem_sh >= trial);
  assign rem_sub = take ? (rem_sh - trial) : rem_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_BITS'(COORD_BITS - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[RAD_BITS-3:0], 2'b00};
      rem_r  <= rem_sub[REM_BITS-1:0];
      root_r <= {root_r[COORD_BITS-2:0], take};
    end
  end

  assign root       = root_r;
  assign stat.done  = done_r;
  assign stat.exact = (rem_r == '0);

endmodule

[hw/rtl/crbe_emit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Circle raster pixel output stage
// Forms the upper and lower rows of a column and presents them in turn on
// the result channel from held registers.
// ---------------------------------------------------------------------------
module crbe_emit #(
  parameter int COORD_BITS = 10
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [COORD_BITS+1:0]     column,
  input  logic [COORD_BITS-1:0]            center_y,
  input  logic [COORD_BITS-1:0]            root,
  input  logic                             exact,
  input  logic                             last,
  output crbe_pkg::emit_stat_t             stat,
  crbe_out_if.source                       out_ch
);
  import crbe_pkg::*;

  localparam int PIX_BITS = COORD_BITS + 2;

  emit_state_t state_r;
  emit_state_t state_nxt;

  logic signed [PIX_BITS-1:0] x_r;
  logic signed [PIX_BITS-1:0] upper_r;
  logic signed [PIX_BITS-1:0] lower_r;
  logic                       last_r;

  logic [PIX_BITS-1:0]        upper_y;
  logic [PIX_BITS-1:0]        lower_y;
  logic [COORD_BITS:0]        root_inc;
  logic                       step_down;
  logic                       out_fire;

  assign root_inc  = {1'b0, root} + (COORD_BITS+1)'(1);
  assign step_down = !exact && ({1'b0, center_y} >= root_inc);
  assign upper_y   = {2'b00, center_y} + {2'b00, root};
  assign lower_y   = {2'b00, center_y} - {2'b00, root}
                     - {{(PIX_BITS-1){1'b0}}, step_down};
  assign out_fire  = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= EM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r     <= column;
      upper_r <= signed'(upper_y);
      lower_r <= signed'(lower_y);
      last_r  <= last;
    end
  end

  always_comb begin
    state_nxt = state_r;
    stat.busy = (state_r != EM_IDLE);
    stat.done = 1'b0;
    unique case (state_r)
      EM_IDLE: begin
        if (start) begin
          state_nxt = EM_UPPER;
        end
      end
      EM_UPPER: begin
        if (out_fire) begin
          state_nxt = EM_LOWER;
        end
      end
      EM_LOWER: begin
        if (out_fire) begin
          state_nxt = EM_IDLE;
          stat.done = 1'b1;
        end
      end
      default: begin
        state_nxt = EM_IDLE;
      end
    endcase
  end

  assign out_ch.valid      = (state_r != EM_IDLE);
  assign out_ch.pixel_x    = x_r;
  assign out_ch.pixel_y    = (state_r == EM_LOWER) ? lower_r : upper_r;
  assign out_ch.lower_half = (state_r == EM_LOWER);
  assign out_ch.last_pixel = (state_r == EM_LOWER) && last_r;

endmodule

[hw/rtl/circle_raster_by_equation.sv]
`timescale 1ns / 1ps
`include "circle_raster_by_equation_macros.svh"
// ---------------------------------------------------------------------------
// Circle raster by the standard equation
// Walks a circle column by column: each column step gives the upper
// and lower pixel of one column from an integer square root.
// ---------------------------------------------------------------------------
// Works on one step transaction at a time. A restart, or a step that yields
// no pixel, completes in the cycle it is accepted. A column step goes from
// acceptance through the two squares, their difference and the bit-serial
// square root unit to the output stage, which presents the upper and then
// the lower pixel and waits while the result channel holds ready low; input
// is ready again only when the step is through. The square root unit, one
// root bit per cycle, takes the largest part of an unstalled step.
// ---------------------------------------------------------------------------
module circle_raster_by_equation #(
  parameter int COORD_BITS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  crbe_in_if.sink     in_ch,
  crbe_out_if.source  out_ch,
  crbe_cfg_if.sink    cfg_ch
);
  import crbe_pkg::*;

  localparam int PIX_BITS  = COORD_BITS + 2;
  localparam int CALC_BITS = COORD_BITS + 3;
  localparam int RAD_BITS  = 2 * COORD_BITS;
  localparam int DD_BITS   = 2 * COORD_BITS + 2;

  crbe_state_t state_r;
  crbe_state_t state_nxt;

  logic [COORD_BITS-1:0]      center_x_r;
  logic [COORD_BITS-1:0]      center_y_r;
  logic [COORD_BITS-1:0]      radius_r;

  logic signed [PIX_BITS-1:0] column_r;
  logic signed [PIX_BITS-1:0] column_nxt;
  logic                       active_r;
  logic                       active_nxt;
  logic                       last_r;
  logic                       last_nxt;
  logic [DD_BITS-1:0]         dd_r;
  logic [DD_BITS-1:0]         dd_nxt;
  logic [RAD_BITS-1:0]        rr_r;
  logic [RAD_BITS-1:0]        rr_nxt;

  logic                       in_fire;
  logic [COORD_BITS:0]        end_sum;
  logic signed [CALC_BITS-1:0] col_ext;
  logic signed [CALC_BITS-1:0] end_ext;
  logic signed [PIX_BITS-1:0] col_start;
  logic signed [PIX_BITS-1:0] dx;
  logic signed [2*PIX_BITS-1:0] dx_sq;
  logic [RAD_BITS-1:0]        r_sq;
  logic [DD_BITS-1:0]         n_diff;
  logic [RAD_BITS-1:0]        radicand;

  logic                       sqrt_start;
  logic [COORD_BITS-1:0]      root;
  sqrt_stat_t                 sqrt_stat;
  logic                       emit_start;
  emit_stat_t                 emit_stat;

  // Configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      radius_r   <= '0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        REG_CENTER_X: center_x_r <= cfg_ch.data;
        REG_CENTER_Y: center_y_r <= cfg_ch.data;
        REG_RADIUS:   radius_r   <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Column arithmetic
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign end_sum   = {1'b0, center_x_r} + {1'b0, radius_r};
  assign col_ext   = {column_r[PIX_BITS-1], column_r};
  assign end_ext   = signed'({2'b00, end_sum});
  assign col_start = signed'({2'b00, center_x_r} - {2'b00, radius_r});
  assign dx        = column_r - signed'({2'b00, center_x_r});
  assign dx_sq     = dx * dx;
  assign r_sq      = radius_r * radius_r;
  assign n_diff    = {2'b00, rr_r} - dd_r;
  assign radicand  = (dd_r > {2'b00, rr_r}) ? '0 : n_diff[RAD_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      column_r <= '0;
      active_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      column_r <= column_nxt;
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r <= last_nxt;
    dd_r   <= dd_nxt;
    rr_r   <= rr_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    column_nxt = column_r;
    active_nxt = active_r;
    last_nxt   = last_r;
    dd_nxt     = dd_r;
    rr_nxt     = rr_r;
    sqrt_start = 1'b0;
    emit_start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.restart) begin
            column_nxt = col_start;
            active_nxt = 1'b1;
          end else if (active_r) begin
            if (col_ext > end_ext) begin
              active_nxt = 1'b0;
            end else begin
              state_nxt = ST_MUL;
            end
          end
        end
      end
      ST_MUL: begin
        dd_nxt    = dx_sq[DD_BITS-1:0];
        rr_nxt    = r_sq;
        last_nxt  = (col_ext == end_ext);
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        sqrt_start = 1'b1;
        state_nxt  = ST_ROOT;
      end
      ST_ROOT: begin
        if (sqrt_stat.done) begin
          emit_start = 1'b1;
          state_nxt  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_stat.done) begin
          column_nxt = column_r + PIX_BITS'(1);
          if (last_r) begin
            active_nxt = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  crbe_isqrt #(
    .COORD_BITS (COORD_BITS)
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (radicand),
    .root     (root),
    .stat     (sqrt_stat)
  );

  crbe_emit #(
    .COORD_BITS (COORD_BITS)
  ) u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (emit_start),
    .column   (column_r),
    .center_y (center_y_r),
    .root     (root),
    .exact    (sqrt_stat.exact),
    .last     (last_r),
    .stat     (emit_stat),
    .out_ch   (out_ch)
  );

  `CRBE_ASSERT_THEN(a_emit_in_state, emit_stat.busy, state_r == ST_EMIT, "output stage busy outside emit")
  `CRBE_ASSERT_THEN(a_root_in_state, sqrt_stat.done, state_r == ST_ROOT, "root done outside root wait")
  `CRBE_ASSERT_NEXT(a_lower_follows, out_ch.valid && out_ch.ready && !out_ch.lower_half, out_ch.valid && out_ch.lower_half, "lower pixel does not follow upper")
  `CRBE_ASSERT_NEXT(a_restart_arms, in_fire && in_ch.restart, active_r, "restart did not start a circle")

endmodule

[bench/tb_circle_raster_by_equation.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Circle raster testbench
// Walks circles through the rasterizer and compares every plotted pixel with
// a column-by-column model of the circle equation. It covers reset state,
// register extremes, exact and inexact roots and registers changed while a
// circle is open. It then applies one long output hold and runs random
// circles under sender gaps and receiver stalls.
// ---------------------------------------------------------------------------
module tb_circle_raster_by_equation;
  import crbe_pkg::*;

  localparam int COORD_BITS    = 10;
  localparam int PIX_BITS      = COORD_BITS + 2;
  localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
  localparam int SETTLE_CYCLES = COORD_BITS + 14;
  localparam int QUIET_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 300;
  localparam int MAX_REPORTS   = 10;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic signed [PIX_BITS-1:0] x;
    logic signed [PIX_BITS-1:0] y;
    logic                       lower;
    logic                       last;
  } plot_pixel_t;

  logic clk;
  logic rst_n;

  crbe_in_if                               in_ch();
  crbe_out_if #(.PIX_BITS(PIX_BITS))       out_ch();
  crbe_cfg_if #(.DATA_BITS(COORD_BITS))    cfg_ch();

  circle_raster_by_equation #(.COORD_BITS(COORD_BITS)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // circle state mirrored by the pixel predictor
  int cx;
  int cy;
  int rad;
  int col;
  bit drawing;

  plot_pixel_t expected_pixels[$];

  int mismatches;
  int pixels_checked;
  int useful_steps;
  int circles_started;
  int reg_writes;
  int quiet_cycles;
  int idle_pct;
  int stall_pct;
  int hold_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int root_floor(input int v);
    int root;
    root = 0;
    for (int b = COORD_BITS; b >= 0; b--) begin
      if ((root | (1 << b)) * (root | (1 << b)) <= v) root = root | (1 << b);
    end
    return root;
  endfunction

  function automatic void plot_column(input logic restart);
    int dx;
    int n;
    int s;
    int lo;
    plot_pixel_t p;
    if (restart) begin
      col = cx - rad;
      drawing = 1'b1;
      circles_started++;
      useful_steps++;
      return;
    end
    if (!drawing) return;
    if (col > cx + rad) begin
      drawing = 1'b0;
      return;
    end
    useful_steps++;
    dx = col - cx;
    n = rad * rad - dx * dx;
    if (n < 0) n = 0;
    s = root_floor(n);
    lo = (s * s != n && cy >= s + 1) ? cy - s - 1 : cy - s;
    p.x = PIX_BITS'(col);
    p.y = PIX_BITS'(cy + s);
    p.lower = 1'b0;
    p.last = 1'b0;
    expected_pixels.push_back(p);
    p.y = PIX_BITS'(lo);
    p.lower = 1'b1;
    p.last = (col == cx + rad);
    expected_pixels.push_back(p);
    if (col == cx + rad) drawing = 1'b0;
    col++;
  endfunction

  function automatic void check_pixel();
    plot_pixel_t want;
    pixels_checked++;
    if (expected_pixels.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("unexpected pixel x=%0d y=%0d lower=%0b last=%0b", out_ch.pixel_x,
                 out_ch.pixel_y, out_ch.lower_half, out_ch.last_pixel);
      return;
    end
    want = expected_pixels.pop_front();
    if (want.x !== out_ch.pixel_x || want.y !== out_ch.pixel_y ||
        want.lower !== out_ch.lower_half || want.last !== out_ch.last_pixel) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("pixel mismatch: expected x=%0d y=%0d lower=%0b last=%0b, got x=%0d y=%0d lower=%0b last=%0b",
                 want.x, want.y, want.lower, want.last, out_ch.pixel_x, out_ch.pixel_y,
                 out_ch.lower_half, out_ch.last_pixel);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) check_pixel();
      if (cfg_ch.valid && cfg_ch.ready) begin
        reg_writes++;
        case (cfg_ch.index)
          REG_CENTER_X: cx = int'(cfg_ch.data);
          REG_CENTER_Y: cy = int'(cfg_ch.data);
          REG_RADIUS:   rad = int'(cfg_ch.data);
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) plot_column(in_ch.restart);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no transaction for %0d cycles", QUIET_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_step(input logic restart);
    int gap;
    gap = 0;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.restart <= restart;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int unsigned value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value[COORD_BITS-1:0];
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_circle(input int x, input int y, input int r);
    write_reg(REG_CENTER_X, x);
    write_reg(REG_CENTER_Y, y);
    write_reg(REG_RADIUS, r);
  endtask

  task automatic test_reset_state();
    send_step(1'b0);
    send_step(1'b0);
    send_step(1'b1);
    send_step(1'b0);
    send_step(1'b0);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    set_circle(COORD_MAX, COORD_MAX, COORD_MAX);
    send_step(1'b1);
    send_step(1'b0);
    send_step(1'b0);
    wait_idle();
    write_reg(REG_CENTER_X, 0);
    write_reg(REG_CENTER_Y, 0);
    send_step(1'b1);
    send_step(1'b0);
    send_step(1'b0);
    wait_idle();
  endtask

  task automatic test_root_cases();
    set_circle(10, 20, 5);
    send_step(1'b1);
    repeat (5) send_step(1'b0);
    wait_idle();
  endtask

  task automatic test_register_change();
    set_circle(50, 2, 10);
    send_step(1'b1);
    repeat (3) send_step(1'b0);
    send_step(1'b1);
    send_step(1'b0);
    wait_idle();
    // shrink the radius so the open column lies outside the circle
    write_reg(REG_RADIUS, 2);
    send_step(1'b0);
    wait_idle();
    write_reg(REG_SPARE, COORD_MAX);
    // move the center left so the open column is past the end
    write_reg(REG_CENTER_X, 20);
    send_step(1'b0);
    send_step(1'b0);
    wait_idle();
  endtask

  task automatic test_output_hold();
    idle_pct = 0;
    stall_pct = 0;
    set_circle(500, 500, 6);
    @(negedge clk);
    hold_left = HOLD_CYCLES;
    send_step(1'b1);
    repeat (14) send_step(1'b0);
    wait_idle();
  endtask

  function automatic int pick_coord();
    case ($urandom_range(9))
      0: return 0;
      1: return COORD_MAX;
      default: return $urandom_range(COORD_MAX);
    endcase
  endfunction

  function automatic int pick_radius();
    case ($urandom_range(39))
      0: return 0;
      1: return $urandom_range(13, 100);
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  task automatic test_random_circles(input int sender_idle, input int receiver_stall,
                                     input int quota);
    int goal;
    int steps;
    idle_pct = sender_idle;
    stall_pct = receiver_stall;
    goal = useful_steps + quota;
    while (useful_steps < goal) begin
      if ($urandom_range(3) == 0) begin
        wait_idle();
        if ($urandom_range(1)) write_reg(REG_CENTER_X, pick_coord());
        if ($urandom_range(1)) write_reg(REG_CENTER_Y, pick_coord());
        if ($urandom_range(1)) write_reg(REG_RADIUS, pick_radius());
        if ($urandom_range(15) == 0) write_reg(REG_SPARE, $urandom_range(COORD_MAX));
      end
      // mostly open a fresh circle; otherwise carry on the one in progress
      if ($urandom_range(9) != 0) send_step(1'b1);
      steps = 2 * rad + 1 + $urandom_range(2);
      if ($urandom_range(7) == 0) steps = $urandom_range(steps);
      repeat (steps) send_step($urandom_range(39) == 0);
    end
    wait_idle();
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.restart = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_CENTER_X;
    cfg_ch.data = '0;
    cx = 0;
    cy = 0;
    rad = 0;
    col = 0;
    drawing = 1'b0;
    mismatches = 0;
    pixels_checked = 0;
    useful_steps = 0;
    circles_started = 0;
    reg_writes = 0;
    quiet_cycles = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_left = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_register_extremes();
    test_root_cases();
    test_register_change();
    test_output_hold();
    test_random_circles(0, 0, 375);
    test_random_circles(60, 0, 375);
    test_random_circles(0, 60, 375);
    test_random_circles(32, 32, 375);
    wait_idle();

    $display("covered %0d column and restart transactions over %0d circles, %0d register writes",
             useful_steps, circles_started, reg_writes);
    $display("checked %0d pixels, %0d mismatches, %0d still pending", pixels_checked,
             mismatches, expected_pixels.size());
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/crbe_pkg.sv
hw/rtl/crbe_in_if.sv
hw/rtl/crbe_out_if.sv
hw/rtl/crbe_cfg_if.sv
hw/rtl/crbe_isqrt.sv
hw/rtl/crbe_emit.sv
hw/rtl/circle_raster_by_equation.sv
bench/tb_circle_raster_by_equation.sv
